/* sv/aifb_pkg.sv */
// Shared types, register indexes, command codes and frame constants for the IR frame builder.
`timescale 1ns / 1ps
`default_nettype none

package aifb_pkg;

	localparam int FRAME_BYTES   = 18;
	localparam int PAYLOAD_BYTES = FRAME_BYTES - 1;
	localparam int IDX_W         = 5;
	localparam int CFG_IDX_W     = 3;
	localparam int CFG_DATA_W    = 8;

	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(FRAME_BYTES - 1);

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_TEMP_MIN      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TEMP_MAX      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_FAN_THREE     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_WIDE_VANE     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_VERTICAL_VANE = 3'd4;

	// Climate modes
	localparam logic [2:0] MODE_HEAT      = 3'd1;
	localparam logic [2:0] MODE_DRY       = 3'd2;
	localparam logic [2:0] MODE_COOL      = 3'd3;
	localparam logic [2:0] MODE_HEAT_COOL = 3'd4;
	localparam logic [2:0] MODE_FAN_ONLY  = 3'd5;

	// Fan settings
	localparam logic [3:0] FAN_LOW    = 4'd1;
	localparam logic [3:0] FAN_MEDIUM = 4'd2;
	localparam logic [3:0] FAN_HIGH   = 4'd3;
	localparam logic [3:0] FAN_MIDDLE = 4'd4;
	localparam logic [3:0] FAN_QUIET  = 4'd5;

	// Swing settings
	localparam logic [1:0] SWING_BOTH       = 2'd1;
	localparam logic [1:0] SWING_VERTICAL   = 2'd2;
	localparam logic [1:0] SWING_HORIZONTAL = 2'd3;

	// Presets
	localparam logic [2:0] PRESET_ECO   = 3'd1;
	localparam logic [2:0] PRESET_BOOST = 3'd2;
	localparam logic [2:0] PRESET_SLEEP = 3'd3;

	// Fixed frame content
	localparam logic [7:0] MARK_0       = 8'h23;
	localparam logic [7:0] MARK_1       = 8'hCB;
	localparam logic [7:0] MARK_2       = 8'h26;
	localparam logic [7:0] MARK_3       = 8'h01;
	localparam logic [7:0] MARK_4       = 8'h00;
	localparam logic [7:0] POWER_ON     = 8'h20;
	localparam logic [7:0] DRY_TEMP     = 8'd24;
	localparam logic [7:0] WIDE_SWING   = 8'hC0;
	localparam logic [7:0] VERT_SWING   = 8'h38;
	localparam logic [7:0] VERT_FIXED   = 8'h40;
	localparam logic [7:0] ECO_MODE     = 8'h58;
	localparam logic [7:0] BOOST_BIT    = 8'h40;
	localparam logic [7:0] ECO_FLAG     = 8'h20;
	localparam logic [7:0] SLEEP_FLAG   = 8'hC1;
	localparam logic [7:0] BOOST_FLAG   = 8'h08;

	typedef struct packed {
		logic [5:0] temp_min;
		logic [5:0] temp_max;
		logic       fan_three_level;
		logic [7:0] default_wide_vane;
		logic [7:0] default_vertical_vane;
	} cfg_t;

	typedef struct packed {
		logic [2:0]        climate_mode;
		logic signed [10:0] target_temp_x16;
		logic [3:0]        fan_setting;
		logic [1:0]        swing_setting;
		logic [2:0]        preset_setting;
	} cmd_t;

	// Bytes 0 to 16 of a frame; the checksum byte is formed on the way out
	typedef logic [PAYLOAD_BYTES-1:0][7:0] frame_t;

endpackage

`default_nettype wire

/* sv/aircon_ir_frame_builder.sv */
// Top level of the air-conditioner IR frame builder: command register, encoder, serializer.
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake               Payload
// cmd       in         cmd_valid / cmd_stall    climate_mode, target_temp_x16, fan_setting,
//                                               swing_setting, preset_setting
// byte      out        byte_valid / byte_stall  frame_byte, byte_index, last_byte
// cfg       in         cfg_valid / cfg_ready    cfg_index, cfg_data
//
// Each command yields 18 byte transfers, one per cycle while byte_stall is low, so a steady
// stream of commands is bounded by the single byte-wide output register.
// A frame's first byte passes the command register, frame buffer and output register in turn.
// Reset clears the command and serializer control state and loads the register defaults.
// A stall on the byte channel holds the output register; a second command waits in the
// command register and further commands are stalled until the current frame has gone out.

module aircon_ir_frame_builder (
	input  logic                 clk,
	input  logic                 arst_n,

	input  logic                 cmd_valid,
	output logic                 cmd_stall,
	input  logic [2:0]           climate_mode,
	input  logic signed [10:0]   target_temp_x16,
	input  logic [3:0]           fan_setting,
	input  logic [1:0]           swing_setting,
	input  logic [2:0]           preset_setting,

	output logic                 byte_valid,
	input  logic                 byte_stall,
	output logic [7:0]           frame_byte,
	output logic [4:0]           byte_index,
	output logic                 last_byte,

	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [2:0]           cfg_index,
	input  logic [7:0]           cfg_data
);
	import aifb_pkg::*;

	cfg_t   cfg;
	cmd_t   cmd_s1;
	logic   valid_s1;
	frame_t frame;
	logic   ser_ready;

	// Configuration registers; writes are expected only while the block is idle.
	aifb_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg_ready (cfg_ready),
		.cfg       (cfg)
	);

	// The command register is free when empty or when its contents move into the
	// serializer in this cycle.
	assign cmd_stall = valid_s1 && !ser_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (!cmd_stall)
			valid_s1 <= cmd_valid;
	end

	always_ff @(posedge clk) begin
		if (cmd_valid && !cmd_stall) begin
			cmd_s1.climate_mode    <= climate_mode;
			cmd_s1.target_temp_x16 <= target_temp_x16;
			cmd_s1.fan_setting     <= fan_setting;
			cmd_s1.swing_setting   <= swing_setting;
			cmd_s1.preset_setting  <= preset_setting;
		end
	end

	// The whole frame apart from its checksum is formed in one pass from the registered command.
	aifb_encode u_encode (
		.cmd   (cmd_s1),
		.cfg   (cfg),
		.frame (frame)
	);

	// The serializer keeps the frame, sends it byte by byte and adds the checksum at the end.
	aifb_serializer u_ser (
		.clk        (clk),
		.arst_n     (arst_n),
		.load_valid (valid_s1),
		.load_frame (frame),
		.load_ready (ser_ready),
		.byte_valid (byte_valid),
		.byte_stall (byte_stall),
		.frame_byte (frame_byte),
		.byte_index (byte_index),
		.last_byte  (last_byte)
	);

`ifndef SYNTHESIS
	// Within a frame the bytes follow one another with no gap once the previous one is taken.
	a_index_step: assert property (@(posedge clk) disable iff (!arst_n)
		(byte_valid && !byte_stall && !last_byte) |=>
			(byte_valid && byte_index == $past(byte_index) + 5'd1))
		else $error("frame byte index did not advance by one");

	// The end-of-frame flag marks exactly the checksum position.
	a_last_flag: assert property (@(posedge clk) disable iff (!arst_n)
		byte_valid |-> (last_byte == (byte_index == LAST_IDX)))
		else $error("last_byte does not match the checksum position");

	// Every frame opens with its first marker byte.
	a_first_marker: assert property (@(posedge clk) disable iff (!arst_n)
		(byte_valid && byte_index == 5'd0) |-> (frame_byte == MARK_0))
		else $error("frame does not start with the marker byte");

	// Commands are held back only while a command is already waiting.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_stall |-> valid_s1)
		else $error("command stalled with an empty command register");
`endif

endmodule

`default_nettype wire

/* sv/aifb_cfg_regs.sv */
// Configuration register file of the IR frame builder.
`timescale 1ns / 1ps
`default_nettype none

module aifb_cfg_regs (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	input  logic [aifb_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [aifb_pkg::CFG_DATA_W-1:0] cfg_data,
	output logic                           cfg_ready,
	output aifb_pkg::cfg_t                 cfg
);
	import aifb_pkg::*;

	cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.temp_min              <= 6'd16;
			cfg_q.temp_max              <= 6'd31;
			cfg_q.fan_three_level       <= 1'b1;
			cfg_q.default_wide_vane     <= 8'h00;
			cfg_q.default_vertical_vane <= 8'h00;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_TEMP_MIN:      cfg_q.temp_min              <= cfg_data[5:0];
				CFG_TEMP_MAX:      cfg_q.temp_max              <= cfg_data[5:0];
				CFG_FAN_THREE:     cfg_q.fan_three_level       <= cfg_data[0];
				CFG_WIDE_VANE:     cfg_q.default_wide_vane     <= cfg_data;
				CFG_VERTICAL_VANE: cfg_q.default_vertical_vane <= cfg_data;
				default: ;
			endcase
		end
	end

endmodule

`default_nettype wire

/* sv/aifb_encode.sv */
// Combinational encoder from one climate command to frame bytes 0 to 16.
`timescale 1ns / 1ps
`default_nettype none

module aifb_encode (
	input  aifb_pkg::cmd_t   cmd,
	input  aifb_pkg::cfg_t   cfg,
	output aifb_pkg::frame_t frame
);
	import aifb_pkg::*;

	logic signed [11:0] t_ext, lo, hi, t_lo, t_cl, off, off_pos, rounded;
	logic [7:0] b5, b6, b7, b8, b9, b14, b15, fan_code, vert_bits;
	logic wide_swing, vert_swing;

	// Temperature: clamp to the configured range, offset from the minimum, round half up
	always_comb begin
		t_ext   = {cmd.target_temp_x16[10], cmd.target_temp_x16};
		lo      = $signed({2'b00, cfg.temp_min, 4'b0000});
		hi      = $signed({2'b00, cfg.temp_max, 4'b0000});
		t_lo    = (t_ext < lo) ? lo : t_ext;
		t_cl    = (t_lo > hi) ? hi : t_lo;
		off     = t_cl - lo;
		off_pos = (off < 12'sd0) ? 12'sd0 : off;
		rounded = off_pos + 12'sd8;
	end

	assign wide_swing = (cmd.swing_setting == SWING_BOTH) ||
		(cmd.swing_setting == SWING_HORIZONTAL);
	assign vert_swing = (cmd.swing_setting == SWING_BOTH) ||
		(cmd.swing_setting == SWING_VERTICAL);

	always_comb begin
		b5 = POWER_ON;
		b6 = 8'h08;
		b8 = 8'h00;
		case (cmd.climate_mode)
			MODE_HEAT:      begin b6 = 8'h08; b8 = 8'h00; end
			MODE_DRY:       begin b6 = 8'h10; b8 = 8'h02; end
			MODE_COOL:      begin b6 = 8'h18; b8 = 8'h06; end
			MODE_HEAT_COOL: begin b6 = 8'h20; b8 = 8'h06; end
			MODE_FAN_ONLY:  begin b6 = 8'h38; b8 = 8'h06; end
			default:        b5 = 8'h00;
		endcase

		if (cmd.climate_mode == MODE_DRY)
			b7 = DRY_TEMP - {2'b00, cfg.temp_min};
		else
			b7 = rounded[11:4];

		b8 = b8 | (wide_swing ? WIDE_SWING : cfg.default_wide_vane);

		case (cmd.fan_setting)
			FAN_LOW:    fan_code = 8'd1;
			FAN_MEDIUM: fan_code = cfg.fan_three_level ? 8'd2 : 8'd3;
			FAN_HIGH:   fan_code = cfg.fan_three_level ? 8'd3 : 8'd4;
			FAN_MIDDLE: fan_code = 8'd2;
			FAN_QUIET:  fan_code = 8'd5;
			default:    fan_code = 8'd0;
		endcase
		vert_bits = vert_swing ? (VERT_SWING | VERT_FIXED)
			: (cfg.default_vertical_vane | VERT_FIXED);
		b9 = fan_code | vert_bits;

		b14 = 8'h00;
		b15 = 8'h00;
		case (cmd.preset_setting)
			PRESET_ECO: begin
				b6  = ECO_MODE;
				b8  = {b8[7:3], 3'd6};
				b14 = ECO_FLAG;
			end
			PRESET_BOOST: begin
				b6  = b6 | BOOST_BIT;
				b15 = BOOST_FLAG;
			end
			PRESET_SLEEP: begin
				b9  = 8'h00;
				b14 = SLEEP_FLAG;
			end
			default: ;
		endcase
	end

	always_comb begin
		frame     = '0;
		frame[0]  = MARK_0;
		frame[1]  = MARK_1;
		frame[2]  = MARK_2;
		frame[3]  = MARK_3;
		frame[4]  = MARK_4;
		frame[5]  = b5;
		frame[6]  = b6;
		frame[7]  = b7;
		frame[8]  = b8;
		frame[9]  = b9;
		frame[14] = b14;
		frame[15] = b15;
	end

endmodule

`default_nettype wire

/* sv/aifb_serializer.sv */
// Frame buffer that sends one byte per cycle while the output is not stalled and appends the running checksum.
`timescale 1ns / 1ps
`default_nettype none

module aifb_serializer (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        load_valid,
	input  aifb_pkg::frame_t            load_frame,
	output logic                        load_ready,
	output logic                        byte_valid,
	input  logic                        byte_stall,
	output logic [7:0]                  frame_byte,
	output logic [aifb_pkg::IDX_W-1:0]  byte_index,
	output logic                        last_byte
);
	import aifb_pkg::*;

	frame_t           frame_q;
	logic             busy_q;
	logic [IDX_W-1:0] cnt_q;
	logic [7:0]       sum_q;
	logic             valid_q;
	logic [7:0]       byte_q;
	logic [IDX_W-1:0] index_q;
	logic             last_q;
	logic             emit, at_last, take;

	assign emit       = busy_q && (!valid_q || !byte_stall);
	assign at_last    = (cnt_q == LAST_IDX);
	assign load_ready = !busy_q || (emit && at_last);
	assign take       = load_valid && load_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			cnt_q   <= '0;
			valid_q <= 1'b0;
		end else begin
			if (take) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (emit) begin
				busy_q <= !at_last;
				cnt_q  <= cnt_q + IDX_W'(1);
			end
			if (emit)
				valid_q <= 1'b1;
			else if (!byte_stall)
				valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			frame_q <= load_frame;
			sum_q   <= 8'h00;
		end else if (emit) begin
			frame_q <= {8'h00, frame_q[PAYLOAD_BYTES-1:1]};
			sum_q   <= sum_q + frame_q[0];
		end
		if (emit) begin
			byte_q  <= at_last ? sum_q : frame_q[0];
			index_q <= cnt_q;
			last_q  <= at_last;
		end
	end

	assign byte_valid = valid_q;
	assign frame_byte = byte_q;
	assign byte_index = index_q;
	assign last_byte  = last_q;

endmodule

`default_nettype wire
